FILE: hw/rtl/ray_box_face_intersection_top_macros.svh
// ---------------------------------------------------------------------------
// ray box face intersection assertion macros
// shared property forms used by the top level checks
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_FACE_INTERSECTION_TOP_MACROS_SVH
`define RAY_BOX_FACE_INTERSECTION_TOP_MACROS_SVH

// same-cycle implication
`define RBFI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rbfi_pkg.sv
// ---------------------------------------------------------------------------
// rbfi_pkg
// types, register codes and face tables for the ray box face intersection
// ---------------------------------------------------------------------------
package rbfi_pkg;

    localparam int FACE_COUNT = 6;
    localparam int ADDR_W     = 5;
    // quotient bits produced by the divider, one per stage
    localparam int QBITS      = 33;
    localparam int DIV_LAT    = QBITS + 1;
    // width of face minus origin
    localparam int NUM_W      = 34;

    localparam logic [2:0] REG_HALF_X = 3'd0;
    localparam logic [2:0] REG_HALF_Y = 3'd1;
    localparam logic [2:0] REG_HALF_Z = 3'd2;
    localparam logic [2:0] REG_VIEW_X = 3'd3;
    localparam logic [2:0] REG_VIEW_Y = 3'd4;
    localparam logic [2:0] REG_VIEW_Z = 3'd5;

    typedef logic [31:0] word_t;
    typedef word_t [2:0] vec3_t;
    typedef logic [30:0] half_t;
    typedef half_t [2:0] half3_t;

    typedef struct packed {
        logic signed [31:0] ray_org_x;
        logic signed [31:0] ray_org_y;
        logic signed [31:0] ray_org_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
        logic signed [31:0] obj_x;
        logic signed [31:0] obj_y;
        logic signed [31:0] obj_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
    } ray_req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } ray_rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        vec3_t                 org;
        vec3_t                 dir;
        vec3_t                 ctr;
        logic                  front_ok;
        logic [FACE_COUNT-1:0] face_ok;
    } job_t;

    // face order -x,+x,-z,+z,-y,+y
    function automatic int face_axis(input int f);
        int ax;
        case (f)
            0, 1:    ax = 0;
            2, 3:    ax = 2;
            default: ax = 1;
        endcase
        return ax;
    endfunction

    function automatic bit face_neg(input int f);
        return ~f[0];
    endfunction

    function automatic word_t mag32(input word_t v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

FILE: hw/rtl/rbfi_front.sv
// ---------------------------------------------------------------------------
// rbfi_front
// accepts requests, computes the viewer front tests and pushes jobs
// ---------------------------------------------------------------------------
module rbfi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rbfi_pkg::ray_req_t req,
    input  rbfi_pkg::half3_t  half,
    input  rbfi_pkg::vec3_t   viewer,
    input  logic              q_full,
    output logic              push_valid,
    output rbfi_pkg::job_t    push_job
);
    import rbfi_pkg::*;

    vec3_t              org_in, dir_in, ctr_in, look_in;
    logic signed [32:0] cv [3];
    logic signed [64:0] dot_next [3];
    logic signed [63:0] fp_next [3];

    logic               a_valid_reg, a_valid_next;
    vec3_t              a_org_reg, a_dir_reg, a_ctr_reg;
    logic signed [64:0] a_dot_reg [3];
    logic signed [63:0] a_fp_reg [3];

    logic signed [66:0]    dot_sum;
    logic signed [67:0]    face_sum [FACE_COUNT];
    logic [FACE_COUNT-1:0] face_ok;

    assign org_in  = {req.ray_org_z, req.ray_org_y, req.ray_org_x};
    assign dir_in  = {req.ray_dir_z, req.ray_dir_y, req.ray_dir_x};
    assign ctr_in  = {req.obj_z, req.obj_y, req.obj_x};
    assign look_in = {req.look_z, req.look_y, req.look_x};

    // per-axis products of the front tests
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cv[k] = $signed({ctr_in[k][31], ctr_in[k]}) - $signed({viewer[k][31], viewer[k]});
            dot_next[k] = $signed(look_in[k]) * cv[k];
            fp_next[k]  = $signed(look_in[k]) * $signed({1'b0, half[k]});
        end
    end

    assign req_stall    = a_valid_reg && q_full;
    assign a_valid_next = req_stall ? a_valid_reg : req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // product stage
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            a_org_reg <= org_in;
            a_dir_reg <= dir_in;
            a_ctr_reg <= ctr_in;
            for (int k = 0; k < 3; k++)
            begin
                a_dot_reg[k] <= dot_next[k];
                a_fp_reg[k]  <= fp_next[k];
            end
        end
    end

    // box and face centre signs
    always_comb
    begin
        dot_sum = a_dot_reg[0] + a_dot_reg[1] + a_dot_reg[2];
        for (int f = 0; f < FACE_COUNT; f++)
        begin
            face_sum[f] = face_neg(f) ? dot_sum - a_fp_reg[face_axis(f)]
                                      : dot_sum + a_fp_reg[face_axis(f)];
            face_ok[f]  = !face_sum[f][67];
        end
    end

    assign push_valid        = a_valid_reg;
    assign push_job.org      = a_org_reg;
    assign push_job.dir      = a_dir_reg;
    assign push_job.ctr      = a_ctr_reg;
    assign push_job.front_ok = !dot_sum[66];
    assign push_job.face_ok  = face_ok;

endmodule

FILE: hw/rtl/rbfi_fifo.sv
// ---------------------------------------------------------------------------
// rbfi_fifo
// short register queue between front and back
// ---------------------------------------------------------------------------
module rbfi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/rbfi_div.sv
// ---------------------------------------------------------------------------
// rbfi_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ---------------------------------------------------------------------------
module rbfi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rbfi_pkg::NUM_W-1:0] num_mag,
    input  logic [31:0]                den_mag,
    input  logic                       neg,
    output logic [31:0]                t_mag,
    output logic                       t_neg
);
    import rbfi_pkg::*;

    localparam int XW = NUM_W + FRAC_BITS;
    localparam int RW = ((XW > 32 + QBITS) ? XW : 32 + QBITS) + 1;

    logic [RW-1:0]    rem_reg [QBITS+1];
    logic [RW-1:0]    rem_next [QBITS+1];
    logic [QBITS-1:0] quo_reg [QBITS+1];
    logic [QBITS-1:0] quo_next [QBITS+1];
    logic [31:0]      den_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];
    logic [RW-1:0]    sh_den [QBITS+1];
    logic             ge [QBITS+1];
    logic             ovf_in;
    logic [QBITS-1:0] lim;

    always_comb
    begin
        // entry stage: scaled dividend and overflow check
        rem_next[0] = RW'({num_mag, {FRAC_BITS{1'b0}}});
        quo_next[0] = '0;
        sh_den[0]   = RW'(den_mag) << QBITS;
        ge[0]       = 1'b0;
        ovf_in      = rem_next[0] >= sh_den[0];
        // one trial subtract per stage
        for (int j = 1; j <= QBITS; j++)
        begin
            sh_den[j]   = RW'(den_reg[j-1]) << (QBITS - j);
            ge[j]       = rem_reg[j-1] >= sh_den[j];
            rem_next[j] = ge[j] ? rem_reg[j-1] - sh_den[j] : rem_reg[j-1];
            quo_next[j] = quo_reg[j-1] | (QBITS'(ge[j]) << (QBITS - j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_in;
            for (int j = 1; j <= QBITS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // saturate magnitude to the signed range
    assign lim   = neg_reg[QBITS] ? QBITS'(33'h080000000) : QBITS'(33'h07fffffff);
    assign t_mag = (ovf_reg[QBITS] || quo_reg[QBITS] > lim) ? lim[31:0] : quo_reg[QBITS][31:0];
    assign t_neg = neg_reg[QBITS];

endmodule

FILE: hw/rtl/rbfi_back.sv
// ---------------------------------------------------------------------------
// rbfi_back
// per-face quotient, hit point, box test and nearest-face selection
// ---------------------------------------------------------------------------
module rbfi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rbfi_pkg::half3_t   half,
    input  logic               head_valid,
    input  rbfi_pkg::job_t     head_job,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rbfi_pkg::ray_rsp_t rsp
);
    import rbfi_pkg::*;

    localparam int PW = 66 - FRAC_BITS;

    logic en;
    logic pipe_valid_reg [DIV_LAT+1];
    job_t job_pipe_reg [DIV_LAT+1];

    logic [FACE_COUNT-1:0][31:0]          tmag_m;
    logic [FACE_COUNT-1:0]                ok_next;
    logic [FACE_COUNT-1:0][2:0][PW-1:0]   pt_next;

    logic                                 p_valid_reg;
    logic [FACE_COUNT-1:0]                p_ok_reg;
    logic [FACE_COUNT-1:0][2:0][PW-1:0]   p_pt_reg;
    logic [FACE_COUNT-1:0][31:0]          p_tmag_reg;

    logic             found;
    logic [31:0]      best;
    logic [2:0][PW-1:0] best_pt;

    logic     rsp_valid_reg;
    ray_rsp_t rsp_reg, rsp_next;

    function automatic logic [31:0] sat_word(input logic signed [PW-1:0] v);
        logic [31:0] r;
        if (v > $signed(PW'(32'h7fffffff)))
        begin
            r = 32'h7fffffff;
        end
        else if (v < $signed({{(PW-32){1'b1}}, 32'h80000000}))
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // whole back pipeline moves unless the result is held
    assign en  = !rsp_valid_reg || !rsp_stall;
    assign pop = en && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_LAT; i++)
            begin
                pipe_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            pipe_valid_reg[0] <= head_valid;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                pipe_valid_reg[i] <= pipe_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_pipe_reg[0] <= head_job;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                job_pipe_reg[i] <= job_pipe_reg[i-1];
            end
        end
    end

    // one lane per face
    for (genvar f = 0; f < FACE_COUNT; f++)
    begin : g_lane
        localparam int AX = face_axis(f);
        localparam bit NG = face_neg(f);

        logic signed [NUM_W-1:0] face_in, num_in;
        logic [NUM_W-1:0]        num_mag;
        logic [31:0]             t_mag;
        logic                    t_neg;
        logic [31:0]             tmag_reg;
        logic                    tneg_reg;
        logic [2:0]              in_box;

        assign face_in = NG ? $signed(head_job.ctr[AX]) - $signed({1'b0, half[AX]})
                            : $signed(head_job.ctr[AX]) + $signed({1'b0, half[AX]});
        assign num_in  = face_in - $signed(head_job.org[AX]);
        assign num_mag = num_in[NUM_W-1] ? NUM_W'(-num_in) : num_in;

        rbfi_div #(
            .FRAC_BITS(FRAC_BITS)
        ) u_div (
            .clk    (clk),
            .en     (en),
            .num_mag(num_mag),
            .den_mag(mag32(head_job.dir[AX])),
            .neg    (num_in[NUM_W-1] ^ head_job.dir[AX][31]),
            .t_mag  (t_mag),
            .t_neg  (t_neg)
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tmag_reg <= t_mag;
                tneg_reg <= t_neg;
            end
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_axis
            logic signed [PW-1:0] lo, hi, pt;

            assign lo = $signed(job_pipe_reg[DIV_LAT].ctr[k]) - $signed({1'b0, half[k]});
            assign hi = $signed(job_pipe_reg[DIV_LAT].ctr[k]) + $signed({1'b0, half[k]});

            if (k == AX)
            begin : g_face
                assign pt = NG ? lo : hi;
            end
            else
            begin : g_off
                logic [63:0]          prod_reg;
                logic signed [PW-1:0] sh, org_e;

                // dir times t, registered before the add
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        prod_reg <= mag32(job_pipe_reg[DIV_LAT-1].dir[k]) * t_mag;
                    end
                end

                assign sh    = $signed(PW'(prod_reg >> FRAC_BITS));
                assign org_e = $signed(job_pipe_reg[DIV_LAT].org[k]);
                assign pt    = (job_pipe_reg[DIV_LAT].dir[k][31] ^ tneg_reg) ? org_e - sh
                                                                             : org_e + sh;
            end

            assign pt_next[f][k] = pt;
            assign in_box[k]     = (pt >= lo) && (pt <= hi);
        end

        assign tmag_m[f]  = tmag_reg;
        assign ok_next[f] = job_pipe_reg[DIV_LAT].front_ok && job_pipe_reg[DIV_LAT].face_ok[f]
                            && (job_pipe_reg[DIV_LAT].dir[AX] != '0) && (&in_box);
    end

    // point stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= pipe_valid_reg[DIV_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ok_reg   <= ok_next;
            p_pt_reg   <= pt_next;
            p_tmag_reg <= tmag_m;
        end
    end

    // nearest accepted face, first wins a tie
    always_comb
    begin
        found   = 1'b0;
        best    = '0;
        best_pt = '0;
        for (int f = 0; f < FACE_COUNT; f++)
        begin
            if (p_ok_reg[f] && (!found || p_tmag_reg[f] < best))
            begin
                found   = 1'b1;
                best    = p_tmag_reg[f];
                best_pt = p_pt_reg[f];
            end
        end
        rsp_next.hit   = found;
        rsp_next.hit_x = found ? sat_word(best_pt[0]) : '0;
        rsp_next.hit_y = found ? sat_word(best_pt[1]) : '0;
        rsp_next.hit_z = found ? sat_word(best_pt[2]) : '0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hw/rtl/ray_box_face_intersection_top.sv
// ---------------------------------------------------------------------------
// ray_box_face_intersection_top
// ray against axis-aligned box, nearest accepted face, Q16.16 fixed point
// ---------------------------------------------------------------------------
//  channel | signals                        | direction
//  req     | req_valid, req_stall, req      | ray and box in
//  rsp     | rsp_valid, rsp_stall, rsp      | hit flag and point out
//  config  | psel, penable, pwrite, paddr.. | register writes and reads
//
// one request per cycle while req_stall is low; an accepted request passes the
// front stage, queue, 34-stage divider, product, point and output registers
// reset loads the register defaults; there is no clearing pass
// a held result freezes the back pipeline; the four-entry queue lets the
// front keep taking requests until it fills
// ---------------------------------------------------------------------------
`include "ray_box_face_intersection_top_macros.svh"

module ray_box_face_intersection_top #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  rbfi_pkg::ray_req_t          req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output rbfi_pkg::ray_rsp_t          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbfi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rbfi_pkg::*;

    half3_t half_reg;
    vec3_t  viewer_reg;
    logic   wr_en;

    logic   push_valid, q_full, q_empty, pop;
    job_t   push_job, head_job;

    // register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg   <= {3{31'd65536}};
            viewer_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_HALF_X: half_reg[0]   <= pwdata[30:0];
                REG_HALF_Y: half_reg[1]   <= pwdata[30:0];
                REG_HALF_Z: half_reg[2]   <= pwdata[30:0];
                REG_VIEW_X: viewer_reg[0] <= pwdata;
                REG_VIEW_Y: viewer_reg[1] <= pwdata;
                REG_VIEW_Z: viewer_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[4:2])
            REG_HALF_X: prdata = {1'b0, half_reg[0]};
            REG_HALF_Y: prdata = {1'b0, half_reg[1]};
            REG_HALF_Z: prdata = {1'b0, half_reg[2]};
            REG_VIEW_X: prdata = viewer_reg[0];
            REG_VIEW_Y: prdata = viewer_reg[1];
            REG_VIEW_Z: prdata = viewer_reg[2];
            default:    prdata = '0;
        endcase
    end

    rbfi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .half      (half_reg),
        .viewer    (viewer_reg),
        .q_full    (q_full),
        .push_valid(push_valid),
        .push_job  (push_job)
    );

    rbfi_fifo #(
        .WIDTH($bits(job_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push_valid && !q_full),
        .wr_data(push_job),
        .pop    (pop),
        .rd_data(head_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    rbfi_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .half      (half_reg),
        .head_valid(!q_empty),
        .head_job  (head_job),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // checks
    `RBFI_ASSERT_IMPLY(a_miss_zero, rsp_valid && !rsp.hit, rsp.hit_x == '0 && rsp.hit_y == '0 && rsp.hit_z == '0, "miss with nonzero point")
    `RBFI_ASSERT_NEXT(a_req_to_front, req_valid && !req_stall, push_valid, "accepted request lost in front")
    `RBFI_ASSERT_NEXT(a_front_hold, push_valid && q_full, push_valid, "front dropped job on full queue")

endmodule
